### design/mavf_pkg.sv
`timescale 1ns / 1ps

package mavf_pkg;

    // fixed widths of the stream fields and registers
    localparam int DATA_W   = 32;
    localparam int WIN_W    = 11;
    localparam int BITS_W   = 6;
    localparam int CFG_IDX_W = 1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BITS   = 1'b1;

    localparam logic [WIN_W-1:0]  WINDOW_LENGTH_RST = 11'd8;
    localparam logic [BITS_W-1:0] SAMPLE_BITS_RST   = 6'd16;

    // sample width after rounding down to whole bytes and clamping
    typedef enum logic [1:0] {
        WIDTH_8  = 2'd0,
        WIDTH_16 = 2'd1,
        WIDTH_24 = 2'd2,
        WIDTH_32 = 2'd3
    } t_width;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic update;
        logic div_start;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

    function automatic logic [DATA_W-1:0] sign_extend(input logic [DATA_W-1:0] word,
                                                      input t_width width);
        logic [DATA_W-1:0] ext;
        case (width)
            WIDTH_8:  ext = {{24{word[7]}}, word[7:0]};
            WIDTH_16: ext = {{16{word[15]}}, word[15:0]};
            WIDTH_24: ext = {{8{word[23]}}, word[23:0]};
            default:  ext = word;
        endcase
        return ext;
    endfunction

    function automatic logic [DATA_W-1:0] width_mask(input t_width width);
        logic [DATA_W-1:0] mask;
        case (width)
            WIDTH_8:  mask = 32'h0000_00ff;
            WIDTH_16: mask = 32'h0000_ffff;
            WIDTH_24: mask = 32'h00ff_ffff;
            default:  mask = 32'hffff_ffff;
        endcase
        return mask;
    endfunction

endpackage

### design/mavf_div.sv
`timescale 1ns / 1ps

module mavf_div
    import mavf_pkg::*;
#(
    parameter int DW = 42,
    parameter int VW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_quot, n_quot;
    logic [VW-1:0] r_rem, n_rem;
    logic [VW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [VW:0]   w_shift;
    logic [VW:0]   w_diff;
    logic          w_ge;

    // restoring division, one quotient bit per cycle
    always_comb begin
        w_shift = {r_rem, r_quot[DW-1]};
        w_ge    = w_shift >= {1'b0, r_dvs};
        w_diff  = w_shift - {1'b0, r_dvs};
        n_quot  = {r_quot[DW-2:0], w_ge};
        n_rem   = w_ge ? w_diff[VW-1:0] : w_shift[VW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

### design/mavf_ctrl.sv
`timescale 1ns / 1ps

module mavf_ctrl
    import mavf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_UPDATE = 5'b00010,
        S_START  = 5'b00100,
        S_WAIT   = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_START;
            end
            S_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_WAIT;
            end
            S_WAIT: begin
                if (i_status.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the quotient until the output register frees up
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

### design/mavf_dp.sv
`timescale 1ns / 1ps

module mavf_dp
    import mavf_pkg::*;
#(
    parameter int MAX_WINDOW = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_clear,
    input  logic [WIN_W-1:0]  i_window,
    input  t_width            i_width,
    input  logic [DATA_W-1:0] i_sample_word,
    input  logic              i_out_ready,
    output t_status           o_status,
    output logic              o_out_valid,
    output logic [DATA_W-1:0] o_filtered_word
);

    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int SUM_W = DATA_W + AW;

    logic [DATA_W-1:0]       r_mem [MAX_WINDOW];
    logic [DATA_W-1:0]       r_rd_data;
    logic [DATA_W-1:0]       r_val;
    logic [AW-1:0]           r_pos, n_pos;
    logic [AW-1:0]           r_wpos;
    logic [WIN_W-1:0]        r_seen, n_seen;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic                    r_neg;
    logic                    r_out_valid;
    logic [DATA_W-1:0]       r_out_data;

    logic [AW-1:0]           w_rd_pos;
    logic [AW:0]             w_inc;
    logic [DATA_W-1:0]       w_old;
    logic signed [DATA_W:0]  w_delta;
    logic [SUM_W-1:0]        w_mag;
    logic                    w_div_done;
    logic [SUM_W-1:0]        w_quot;
    logic [DATA_W-1:0]       w_res;

    always_comb begin
        w_rd_pos = (32'(r_pos) >= 32'(i_window)) ? '0 : r_pos;
        // slots at or past the fill count have not been written since the clear
        w_old    = (32'(r_wpos) < 32'(r_seen)) ? r_rd_data : '0;
        w_delta  = $signed({r_val[DATA_W-1], r_val}) - $signed({w_old[DATA_W-1], w_old});
        n_sum    = r_sum + SUM_W'(w_delta);
        w_inc    = {1'b0, r_wpos} + 1'b1;
        n_pos    = (32'(w_inc) >= 32'(i_window)) ? '0 : w_inc[AW-1:0];
        n_seen   = (r_seen < i_window) ? r_seen + 1'b1 : i_window;
        w_mag    = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_pos  <= '0;
            r_seen <= '0;
        end else if (i_clear) begin
            r_sum  <= '0;
            r_pos  <= '0;
            r_seen <= '0;
        end else if (i_cmd.update) begin
            r_sum  <= n_sum;
            r_pos  <= n_pos;
            r_seen <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_data <= r_mem[w_rd_pos];
            r_wpos    <= w_rd_pos;
            r_val     <= sign_extend(i_sample_word, i_width);
        end
        if (i_cmd.update) begin
            r_mem[r_wpos] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_neg <= r_sum[SUM_W-1];
        end
    end

    mavf_div #(
        .DW (SUM_W),
        .VW (WIN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_mag),
        .i_divisor  (r_seen),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign w_res = r_neg ? (32'd0 - w_quot[DATA_W-1:0]) : w_quot[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= w_res & width_mask(i_width);
        end
    end

    assign o_status.div_done = w_div_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_filtered_word   = r_out_data;

endmodule

### design/moving_average_filter.sv
`timescale 1ns / 1ps
// one request in flight: a new request is taken only once the last result is in the output
//   register, which waits while the result stream is stalled; the bit-serial divider makes
//   one quotient bit per cycle over the 32 + log2(MAX_WINDOW) bit running sum
// reset: synchronous, active low; window_length back to 8, sample_bits back to 16,
//   running sum, ring position and fill count cleared, no request or result pending

module moving_average_filter
    import mavf_pkg::*;
#(
    parameter int MAX_WINDOW = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input request stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [DATA_W-1:0]    i_s_axis_tdata,    // [31:0] sample_word
    // result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [DATA_W-1:0]    o_m_axis_tdata,    // [31:0] filtered_word
    // register writes
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WIN_W-1:0]     i_cfg_data
);

    // configuration registers
    logic [WIN_W-1:0]  r_window_length;
    logic [BITS_W-1:0] r_sample_bits;
    logic              w_clear;
    logic [WIN_W-1:0]  w_window;
    t_width            w_width;

    t_cmd              w_cmd;
    t_status           w_status;

    // a window_length write also empties the ring (sum, position and fill count)
    assign w_clear = i_cfg_wr_en && (i_cfg_index == CFG_WINDOW_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WINDOW_LENGTH_RST;
            r_sample_bits   <= SAMPLE_BITS_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_WINDOW_LENGTH: r_window_length <= i_cfg_data;
                CFG_SAMPLE_BITS:   r_sample_bits   <= i_cfg_data[BITS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // zero window acts as a window of one, anything above the ring depth saturates
    always_comb begin
        if (r_window_length == '0) begin
            w_window = WIN_W'(1);
        end else if (32'(r_window_length) > 32'(MAX_WINDOW)) begin
            w_window = WIN_W'(MAX_WINDOW);
        end else begin
            w_window = r_window_length;
        end
    end

    // sample width: whole bytes of sample_bits, clamped to one through four
    always_comb begin
        case (r_sample_bits[5:3]) inside
            3'd0, 3'd1: w_width = WIDTH_8;
            3'd2:       w_width = WIDTH_16;
            3'd3:       w_width = WIDTH_24;
            default:    w_width = WIDTH_32;
        endcase
    end

    // sequencer: accept, ring update, divide, hand off to the output register
    mavf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (w_status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // ring memory, running sum, divider and output register
    mavf_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_clear         (w_clear),
        .i_window        (w_window),
        .i_width         (w_width),
        .i_sample_word   (i_s_axis_tdata),
        .i_out_ready     (i_m_axis_tready),
        .o_status        (w_status),
        .o_out_valid     (o_m_axis_tvalid),
        .o_filtered_word (o_m_axis_tdata)
    );

    // one request in flight: the slave side closes right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request accepted while another is in flight");

    // byte-wide samples leave the upper result bits clear
    a_narrow_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (w_width == WIDTH_8)) |-> (o_m_axis_tdata[31:8] == 24'd0))
        else $error("result has bits above the sample width");

    // reset leaves the block empty and ready
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_axis_tvalid && o_s_axis_tready))
        else $error("block not empty after reset");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import mavf_pkg::*;

    localparam int MAX_WINDOW    = 1024;
    localparam int SETTLE_CYCLES = 64;        // idle time before each register write and before the end of the run
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int REPORT_LIMIT  = 10;
    localparam int WIN_CODE_MAX  = (1 << WIN_W) - 1;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [DATA_W-1:0]    m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WIN_W-1:0]     cfg_data = '0;

    // stream pacing, set by the tests
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold     = 0;

    int error_count = 0;
    int cycle_count = 0;

    logic [DATA_W-1:0] expected_averages[$];
    logic [DATA_W-1:0] oldest_average;

    // predictor state: register copies, sample ring, running sum
    int     win_setting;
    int     bits_setting;
    int     ring[MAX_WINDOW];
    longint ring_sum;
    int     ring_pos;
    int     fill_count;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    moving_average_filter #(
        .MAX_WINDOW(MAX_WINDOW)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    function automatic void clear_ring();
        foreach (ring[k]) ring[k] = 0;
        ring_sum   = 0;
        ring_pos   = 0;
        fill_count = 0;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [WIN_W-1:0] value);
        if (idx == CFG_WINDOW_LENGTH) begin
            win_setting = int'(value);
            clear_ring();
        end else if (idx == CFG_SAMPLE_BITS) begin
            bits_setting = int'(value[BITS_W-1:0]);
        end
    endfunction

    function automatic int active_window();
        if (win_setting == 0) return 1;
        if (win_setting > MAX_WINDOW) return MAX_WINDOW;
        return win_setting;
    endfunction

    // whole bytes only, one to four of them
    function automatic int active_width();
        int bytes;
        bytes = bits_setting >> 3;
        if (bytes < 1) bytes = 1;
        if (bytes > 4) bytes = 4;
        return bytes * 8;
    endfunction

    function automatic logic [DATA_W-1:0] sample_mask();
        if (active_width() == DATA_W) return {DATA_W{1'b1}};
        return (32'd1 << active_width()) - 32'd1;
    endfunction

    // advance the ring by one sample and return the truncated mean
    function automatic logic [DATA_W-1:0] predict_average(input logic [DATA_W-1:0] word);
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] ext;
        int                width;
        int                win;
        int                pos;
        longint            quotient;
        mask  = sample_mask();
        width = active_width();
        win   = active_window();
        ext   = word & mask;
        if (ext[width-1]) ext = ext | ~mask;
        pos = (ring_pos >= win) ? 0 : ring_pos;
        ring_sum  = ring_sum - longint'(ring[pos]);
        ring[pos] = int'(ext);
        ring_sum  = ring_sum + longint'(ring[pos]);
        ring_pos  = (pos + 1 >= win) ? 0 : pos + 1;
        if (fill_count < win) fill_count++;
        // signed division truncates toward zero
        quotient = ring_sum / longint'(fill_count);
        return quotient[DATA_W-1:0] & mask;
    endfunction

    // lean 2 pushes toward the largest positive sample, lean 3 toward the most negative
    function automatic logic [DATA_W-1:0] random_sample(input int lean);
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] word;
        int                pick;
        mask = sample_mask();
        word = $urandom;
        pick = $urandom_range(9);
        if (lean == 2 && pick < 7) pick = 0;
        if (lean == 3 && pick < 7) pick = 1;
        case (pick)
            0: word = (word & ~mask) | (mask >> 1);
            1: word = (word & ~mask) | (mask & ~(mask >> 1));
            2: word = word & ~mask;
            3: word = word | mask;
            default: ;
        endcase
        return word;
    endfunction

    function automatic void report_error(input string what, input logic [DATA_W-1:0] want,
                                         input logic [DATA_W-1:0] got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t: %s expected %h got %h", $time, what, want, got);
    endfunction

    // one request on the input stream, predicted at the edge it is taken
    task automatic send_sample(input logic [DATA_W-1:0] word);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do begin
            @(posedge clk);
        end while (!s_tready);
        expected_averages.push_back(predict_average(word));
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_averages.size() != 0) @(posedge clk);
    endtask

    // registers change only with the block idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [WIN_W-1:0] value);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        apply_register(idx, value);
        cfg_wr_en <= 1'b0;
    endtask

    // result side: check each accepted result, then pick the next ready
    always @(posedge clk) begin
        if (m_tvalid && m_tready) begin
            if (expected_averages.size() == 0) begin
                report_error("result with nothing pending:", '0, m_tdata);
            end else begin
                oldest_average = expected_averages.pop_front();
                if (m_tdata !== oldest_average)
                    report_error("filtered_word mismatch:", oldest_average, m_tdata);
            end
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // reset values: window of 8, 16-bit samples, warm-up then wrap
    task automatic test_reset_defaults();
        send_sample(32'h0000_7fff);
        send_sample(32'hffff_8000);
        send_sample(32'h1234_7fff);
        send_sample(32'h0000_0000);
        send_sample(32'habcd_ffff);
        send_sample(32'h0000_8000);
        send_sample(32'h5555_0001);
        send_sample(32'h0000_7ffe);
        send_sample(32'hffff_ffff);
        send_sample(32'h8000_8001);
        wait_for_results();
    endtask

    // zero and oversized windows, odd and out-of-range widths
    task automatic test_register_corners();
        write_register(CFG_WINDOW_LENGTH, '0);
        write_register(CFG_SAMPLE_BITS, 11'd7);
        send_sample(32'h0000_007f);
        send_sample(32'hffff_ff80);
        send_sample(32'h0000_0101);
        write_register(CFG_WINDOW_LENGTH, WIN_CODE_MAX[WIN_W-1:0]);
        write_register(CFG_SAMPLE_BITS, 11'd63);
        send_sample(32'h7fff_ffff);
        send_sample(32'h8000_0000);
        send_sample(32'hffff_ffff);
        write_register(CFG_WINDOW_LENGTH, 11'd3);
        write_register(CFG_SAMPLE_BITS, 11'd27);
        send_sample(32'hff7f_ffff);
        send_sample(32'h0080_0000);
        send_sample(32'h00ff_fffe);
        send_sample(32'h0000_0003);
        wait_for_results();
    endtask

    // stored samples keep their old extension after a width change
    task automatic test_width_change();
        write_register(CFG_WINDOW_LENGTH, 11'd4);
        write_register(CFG_SAMPLE_BITS, 11'd32);
        send_sample(32'h8000_0000);
        send_sample(32'h8000_0000);
        write_register(CFG_SAMPLE_BITS, 11'd8);
        send_sample(32'h0000_007f);
        send_sample(32'h0000_0001);
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int item_total);
        logic [WIN_W-1:0] window;
        logic [WIN_W-1:0] bits;
        int               sent;
        int               burst;
        int               lean;
        sent = 0;
        while (sent < item_total) begin
            case ($urandom_range(7))
                0: window = 11'd1;
                1: window = 11'd0;
                2: window = MAX_WINDOW[WIN_W-1:0];
                3: window = WIN_W'($urandom_range(MAX_WINDOW + 1, WIN_CODE_MAX));
                default: window = WIN_W'($urandom_range(2, 48));
            endcase
            case ($urandom_range(5))
                0: bits = WIN_W'($urandom_range(0, WIN_CODE_MAX));  // upper bits dropped
                1: bits = 11'd8;
                2: bits = 11'd16;
                3: bits = 11'd24;
                4: bits = 11'd32;
                default: bits = WIN_W'($urandom_range(0, 63));
            endcase
            // skipping the window write keeps the ring across a width change
            if ($urandom_range(2) != 0) write_register(CFG_WINDOW_LENGTH, window);
            write_register(CFG_SAMPLE_BITS, bits);
            burst = $urandom_range(15, 60);
            lean  = $urandom_range(3);
            repeat (burst) send_sample(random_sample(lean));
            sent += burst;
        end
    endtask

    // long receiver stall fills the block and stalls the input side
    task automatic test_backpressure();
        write_register(CFG_WINDOW_LENGTH, 11'd5);
        write_register(CFG_SAMPLE_BITS, 11'd16);
        rx_hold = 600;
        repeat (24) send_sample(random_sample(0));
        // pause until everything is out, then carry on in the same window
        wait_for_results();
        repeat (8) send_sample(random_sample(3));
        wait_for_results();
    endtask

    initial begin
        win_setting  = int'(WINDOW_LENGTH_RST);
        bits_setting = int'(SAMPLE_BITS_RST);
        clear_ring();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_corners();
        test_width_change();

        tx_idle_pct = 9;
        rx_idle_pct = 81;
        test_random_traffic(200);
        tx_idle_pct = 81;
        rx_idle_pct = 9;
        test_random_traffic(200);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(200);
        test_backpressure();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_averages.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
